@@ hdl/jdcs_pkg.sv @@
// ----------------------------------------------------------------------------
// jdcs_pkg
// Shared types, constants and the steering curve function of the joystick
// drive command shaper.
// ----------------------------------------------------------------------------
package jdcs_pkg;

	localparam int AXIS_W          = 16;
	localparam int STEP_W          = 15;
	localparam int THR_W           = 16;
	localparam int ANGLE_W         = 7;
	localparam int CFG_IDX_W       = 1;

	localparam int DEF_STEER_TABLE_BITS = 8;
	localparam int DEF_AXIS_BITS        = 16;

	localparam logic [15:0] DECAY_Q16    = 16'd64225;
	localparam logic [14:0] THROTTLE_MAX = 15'd25600;
	localparam int          STEER_LIMIT  = 45;
	localparam logic [STEP_W-1:0] STEP_RESET = 15'd512;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_STEP = 1'b1;

	typedef logic signed [THR_W-1:0]   throttle_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	// Main result of one item as held in the output stage.
	typedef struct packed {
		throttle_t throttle;
		angle_t    angle;
		logic      auto_on;
		logic      mode_held;
	} result_t;

	// Largest k in 0..45 with k^2 * N^3 <= 22500 * i^3, N = 2^bits.
	// Only evaluated on constants, at elaboration.
	function automatic logic [5:0] steer_entry(input int unsigned i, input int unsigned bits);
		longint unsigned n;
		longint unsigned n3;
		longint unsigned rhs;
		longint unsigned cc;
		logic [5:0]      k;
		n   = 64'd1 << bits;
		n3  = n * n * n;
		rhs = 64'd22500 * i * i * i;
		k   = '0;
		for (int c = 1; c <= STEER_LIMIT; c++) begin
			cc = longint'(c) * longint'(c);
			if (cc * n3 <= rhs) begin
				k = 6'(c);
			end
		end
		return k;
	endfunction

endpackage

@@ hdl/jdcs_ifs.sv @@
// ----------------------------------------------------------------------------
// jdcs channel interfaces
// Valid/ready channels for joystick samples and for shaped drive commands.
// ----------------------------------------------------------------------------
interface jdcs_sample_if;
	import jdcs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] throttle_axis;
	logic signed [AXIS_W-1:0] steer_axis;
	logic                     stop_button;
	logic                     mode_button;

	modport source (output valid, throttle_axis, steer_axis, stop_button, mode_button,
		input ready);
	modport sink (input valid, throttle_axis, steer_axis, stop_button, mode_button,
		output ready);
endinterface

interface jdcs_cmd_if;
	import jdcs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [THR_W-1:0]   throttle_out;
	logic signed [ANGLE_W-1:0] steer_angle;
	logic                      auto_mode_out;
	logic                      auto_mode_shown;
	logic                      stop_result;
	logic                      last_result;

	modport source (output valid, throttle_out, steer_angle, auto_mode_out, auto_mode_shown,
		stop_result, last_result, input ready);
	modport sink (input valid, throttle_out, steer_angle, auto_mode_out, auto_mode_shown,
		stop_result, last_result, output ready);
endinterface

@@ hdl/jdcs_throttle.sv @@
// ----------------------------------------------------------------------------
// jdcs_throttle
// Next throttle level: stop clear, decay by 0.98, slew toward the stick
// target and saturation at +/-100.
// ----------------------------------------------------------------------------
module jdcs_throttle #(
	parameter int AXIS_BITS = jdcs_pkg::DEF_AXIS_BITS
) (
	input  jdcs_pkg::throttle_t               level,
	input  logic [jdcs_pkg::AXIS_W-1:0]       throttle_axis,
	input  logic                              stop,
	input  logic [jdcs_pkg::STEP_W-1:0]       accel_step,
	input  logic [jdcs_pkg::STEP_W-1:0]       decel_step,
	output jdcs_pkg::throttle_t               level_next
);
	import jdcs_pkg::*;

	localparam logic signed [17:0] SAT_HI = 18'sd25600;
	localparam logic signed [17:0] SAT_LO = -18'sd25600;

	logic [AXIS_BITS-1:0]    raw;
	logic                    neg;
	logic                    nonzero;
	logic [AXIS_BITS-1:0]    tmag;
	logic [AXIS_BITS+14:0]   tprod;
	logic [14:0]             tm;
	logic signed [THR_W-1:0] base;
	logic [14:0]             bmag;
	logic [30:0]             dprod;
	logic [14:0]             dmag;
	logic signed [17:0]      decayed;
	logic signed [17:0]      target;
	logic signed [17:0]      diff;
	logic [16:0]             diff_mag;
	logic                    up;
	logic [STEP_W-1:0]       step;
	logic signed [17:0]      moved;
	logic signed [17:0]      slewed;

	always_comb begin
		raw     = throttle_axis[AXIS_BITS-1:0];
		neg     = raw[AXIS_BITS-1];
		nonzero = |raw;
		tmag    = neg ? AXIS_BITS'(~raw + 1'b1) : raw;
		tprod   = (AXIS_BITS+15)'(tmag) * (AXIS_BITS+15)'(THROTTLE_MAX);
		tm      = 15'(tprod >> (AXIS_BITS - 1));

		// A stop press clears the level before the decay.
		base    = stop ? '0 : level;
		bmag    = base[THR_W-1] ? 15'(-base) : base[14:0];
		dprod   = 31'(bmag) * 31'(DECAY_Q16);
		dmag    = dprod[30:16];
		decayed = base[THR_W-1] ? -$signed({3'b000, dmag}) : $signed({3'b000, dmag});

		// Target throttle has the opposite sign of the stick.
		target  = (!neg && nonzero) ? -$signed({3'b000, tm}) : $signed({3'b000, tm});
		diff    = target - decayed;
		diff_mag = diff[17] ? 17'(-diff) : diff[16:0];
		up      = !diff[17] && (diff != '0);
		step    = up ? accel_step : decel_step;
		moved   = up ? decayed + $signed({3'b000, step}) : decayed - $signed({3'b000, step});

		if (diff_mag <= {2'b00, step}) begin
			slewed = target;
		end else if (moved > SAT_HI) begin
			slewed = SAT_HI;
		end else if (moved < SAT_LO) begin
			slewed = SAT_LO;
		end else begin
			slewed = moved;
		end

		level_next = nonzero ? THR_W'(slewed) : THR_W'(decayed);
	end

endmodule

@@ hdl/jdcs_steer.sv @@
// ----------------------------------------------------------------------------
// jdcs_steer
// Steering angle: dead zone of 0.1, then the 150*|x|^1.5 curve from a
// constant table, signed by the stick direction.
// ----------------------------------------------------------------------------
module jdcs_steer #(
	parameter int STEER_TABLE_BITS = jdcs_pkg::DEF_STEER_TABLE_BITS,
	parameter int AXIS_BITS        = jdcs_pkg::DEF_AXIS_BITS
) (
	input  logic [jdcs_pkg::AXIS_W-1:0] steer_axis,
	output jdcs_pkg::angle_t            angle
);
	import jdcs_pkg::*;

	localparam int LUT_N = 1 << STEER_TABLE_BITS;
	localparam logic [AXIS_BITS+3:0] FULL_SCALE = (AXIS_BITS+4)'(1) << (AXIS_BITS - 1);
	localparam logic [STEER_TABLE_BITS:0] IDX_MAX = (STEER_TABLE_BITS+1)'(LUT_N);

	logic [5:0] steer_lut [0:LUT_N];

	for (genvar gi = 0; gi <= LUT_N; gi++) begin : g_lut
		assign steer_lut[gi] = steer_entry(gi, STEER_TABLE_BITS);
	end

	logic [AXIS_BITS-1:0]                  raw;
	logic                                  neg;
	logic [AXIS_BITS-1:0]                  mag;
	logic [AXIS_BITS+3:0]                  mag10;
	logic [AXIS_BITS+STEER_TABLE_BITS-1:0] scaled;
	logic [STEER_TABLE_BITS:0]             idx;
	logic [5:0]                            k;

	always_comb begin
		raw    = steer_axis[AXIS_BITS-1:0];
		neg    = raw[AXIS_BITS-1];
		mag    = neg ? AXIS_BITS'(~raw + 1'b1) : raw;
		mag10  = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
		scaled = {mag, {STEER_TABLE_BITS{1'b0}}} >> (AXIS_BITS - 1);
		idx    = scaled[STEER_TABLE_BITS:0];
		if (idx > IDX_MAX) begin
			idx = IDX_MAX;
		end
		k = steer_lut[idx];
		if (mag10 <= FULL_SCALE) begin
			angle = '0;
		end else if (neg) begin
			angle = -$signed({1'b0, k});
		end else begin
			angle = $signed({1'b0, k});
		end
	end

endmodule

@@ hdl/joystick_drive_command_shaper_core.sv @@
// ----------------------------------------------------------------------------
// joystick_drive_command_shaper_core
// Turns joystick samples into throttle and steering commands.
// ----------------------------------------------------------------------------
// Samples enter on sample_ch and commands leave on cmd_ch, both valid/ready.
// accel_step and decel_step are written through cfg_we/cfg_index/cfg_data,
// which the user must do only while the block is idle (the block itself does
// not enforce this); both reset to 512 (Q8.8). A sample is held in an input
// register, computed combinationally and moved into the output register,
// from which its first command is shown. A sample without a stop press
// gives one command; with a stop press it gives a zero stop command first
// and its main command next.
// Throughput is one sample per cycle while cmd_ch.ready is high; a stop
// press holds the output register for its extra stop command.
// While cmd_ch.ready is low the output register holds and the input
// register still takes one more sample; then sample_ch.ready drops.
// Reset clears the throttle level, the mode button history, the auto mode
// flag and both valid bits.
// ----------------------------------------------------------------------------
module joystick_drive_command_shaper_core #(
	parameter int STEER_TABLE_BITS = jdcs_pkg::DEF_STEER_TABLE_BITS,
	parameter int AXIS_BITS        = jdcs_pkg::DEF_AXIS_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jdcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jdcs_pkg::STEP_W-1:0]       cfg_data,
	jdcs_sample_if.sink                       sample_ch,
	jdcs_cmd_if.source                        cmd_ch
);
	import jdcs_pkg::*;

	// Configuration registers.
	logic [STEP_W-1:0] accel_step_q;
	logic [STEP_W-1:0] decel_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_step_q <= STEP_RESET;
			decel_step_q <= STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_STEP: accel_step_q <= cfg_data;
				REG_DECEL_STEP: decel_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic              valid_s1;
	logic [AXIS_W-1:0] taxis_s1;
	logic [AXIS_W-1:0] saxis_s1;
	logic              stop_s1;
	logic              mode_s1;

	// Output register.
	logic    valid_q;
	logic    stop_pend_q;
	result_t res_q;

	// Item state.
	throttle_t level_q;
	logic      mode_prev_q;
	logic      auto_q;

	logic      advance;
	logic      take;
	logic      in_hs;
	logic      out_hs;
	throttle_t level_next;
	angle_t    angle;
	logic      auto_next;

	// The output register frees up when empty or when its last command leaves.
	assign advance         = !valid_q || (cmd_ch.ready && !stop_pend_q);
	assign take            = advance && valid_s1;
	assign sample_ch.ready = !valid_s1 || advance;
	assign in_hs           = sample_ch.valid && sample_ch.ready;
	assign out_hs          = cmd_ch.valid && cmd_ch.ready;
	assign auto_next       = auto_q ^ (mode_s1 && !mode_prev_q);

	jdcs_throttle #(
		.AXIS_BITS (AXIS_BITS)
	) u_throttle (
		.level         (level_q),
		.throttle_axis (taxis_s1),
		.stop          (stop_s1),
		.accel_step    (accel_step_q),
		.decel_step    (decel_step_q),
		.level_next    (level_next)
	);

	jdcs_steer #(
		.STEER_TABLE_BITS (STEER_TABLE_BITS),
		.AXIS_BITS        (AXIS_BITS)
	) u_steer (
		.steer_axis (saxis_s1),
		.angle      (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_hs) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs) begin
			taxis_s1 <= sample_ch.throttle_axis;
			saxis_s1 <= sample_ch.steer_axis;
			stop_s1  <= sample_ch.stop_button;
			mode_s1  <= sample_ch.mode_button;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			stop_pend_q <= 1'b0;
			level_q     <= '0;
			mode_prev_q <= 1'b0;
			auto_q      <= 1'b0;
		end else if (advance) begin
			valid_q     <= valid_s1;
			stop_pend_q <= valid_s1 && stop_s1;
			if (valid_s1) begin
				level_q     <= level_next;
				mode_prev_q <= mode_s1;
				auto_q      <= auto_next;
			end
		end else if (out_hs) begin
			// Stop command taken; the main command of the same sample follows.
			stop_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.throttle  <= level_next;
			res_q.angle     <= angle;
			res_q.auto_on   <= auto_next;
			res_q.mode_held <= mode_s1;
		end
	end

	assign cmd_ch.valid           = valid_q;
	assign cmd_ch.throttle_out    = stop_pend_q ? '0 : res_q.throttle;
	assign cmd_ch.steer_angle     = stop_pend_q ? '0 : res_q.angle;
	assign cmd_ch.auto_mode_out   = !stop_pend_q && res_q.auto_on;
	assign cmd_ch.auto_mode_shown = !stop_pend_q && res_q.mode_held;
	assign cmd_ch.stop_result     = stop_pend_q;
	assign cmd_ch.last_result     = !stop_pend_q;

	a_stop_then_main: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs && cmd_ch.stop_result |=> cmd_ch.valid && !cmd_ch.stop_result)
		else $error("stop command not followed by its main command");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= 16'sd25600 && level_q >= -16'sd25600)
		else $error("throttle level out of range");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ch.valid |-> cmd_ch.steer_angle <= 7'sd45 && cmd_ch.steer_angle >= -7'sd45)
		else $error("steering angle out of range");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(level_q) && $stable(auto_q) && $stable(mode_prev_q))
		else $error("state changed without a sample moving to the output");

endmodule
